### sv/ipe_pkg.sv
package ipe_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned OpWidth   = 3;
   localparam int unsigned ValDepth  = 4;
   localparam int unsigned OpsDepth  = 3;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_OPER  = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   localparam logic [2:0] OP_MUL = 3'd0;
   localparam logic [2:0] OP_DIV = 3'd1;
   localparam logic [2:0] OP_ADD = 3'd2;
   localparam logic [2:0] OP_SUB = 3'd3;
   localparam logic [2:0] OP_REM = 3'd4;

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         operator_code;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic start_reduce;
      logic push;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic pending_any;
      logic reduce_needed;
      logic stack_full;
      logic reduce_busy;
   } sts_type;

   function automatic logic [1:0] prec_of(input logic [2:0] op);
      logic [1:0] p;
      if (op == OP_MUL || op == OP_DIV) p = 2'd3;
      else if (op == OP_ADD || op == OP_SUB) p = 2'd2;
      else p = 2'd1;
      return p;
   endfunction

endpackage

### sv/ipe_divider.sv
module ipe_divider #(
   parameter int unsigned Width = ipe_pkg::DataWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [Width-1:0] dividend,
   input  logic [Width-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [Width-1:0] quotient,
   output logic [Width-1:0] remainder
);

   localparam int unsigned CntWidth = $clog2(Width + 1);

   logic [Width-1:0]    quo_ff, quo_in;
   logic [Width-1:0]    rem_ff, rem_in;
   logic [Width-1:0]    dvs_ff, dvs_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [Width:0]      trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[Width-1]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CntWidth'(Width);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[Width]) begin
            rem_in = trial[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[Width-2:0], quo_ff[Width-1]};
            quo_in = {quo_ff[Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### sv/ipe_datapath.sv
module ipe_datapath #(
   parameter int unsigned Width = ipe_pkg::DataWidth
) (
   input  logic              clock,
   input  logic              reset,
   input  ipe_pkg::req_type  item,
   input  ipe_pkg::cmd_type  cmd,
   output ipe_pkg::sts_type  sts,
   output ipe_pkg::rsp_type  result
);

   logic [Width-1:0] val_ff [ipe_pkg::ValDepth];
   logic [Width-1:0] val_in [ipe_pkg::ValDepth];
   logic [2:0]       ops_ff [ipe_pkg::OpsDepth];
   logic [2:0]       ops_in [ipe_pkg::OpsDepth];
   logic [1:0]       cnt_ff, cnt_in;
   logic             err_ff, err_in;
   logic [2:0]       item_op_ff, item_op_in;
   logic [Width-1:0] item_val_ff, item_val_in;
   logic             red_ff, red_in;
   logic [1:0]       ridx;
   logic [2:0]       rop;
   logic [Width-1:0] ra, rb, prod_ff, res;
   logic             mul_ff, mul_in;
   logic             div_start, div_busy, div_done;
   logic [Width-1:0] ua, ub, q, r, qs, rs;
   logic             sa_ff, sb_ff;
   logic             red_done;
   logic             zero_div;

   assign ridx = cnt_ff - 2'd1;
   assign rop  = ops_ff[ridx];
   assign ra   = val_ff[ridx];
   assign rb   = val_ff[cnt_ff];
   assign ua   = ra[Width-1] ? -ra : ra;
   assign ub   = rb[Width-1] ? -rb : rb;
   assign zero_div  = (rb == '0);
   assign div_start = cmd.start_reduce && (rop == ipe_pkg::OP_DIV || rop == ipe_pkg::OP_REM)
                      && !zero_div;
   assign mul_in    = cmd.start_reduce && rop == ipe_pkg::OP_MUL;

   ipe_divider #(.Width(Width)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(ua), .divisor(ub), .busy(div_busy), .done(div_done),
      .quotient(q), .remainder(r)
   );

   assign qs = (sa_ff ^ sb_ff) ? -q : q;
   assign rs = sa_ff ? -r : r;

   always_comb begin
      red_done = 1'b0;
      res      = '0;
      if (red_ff) begin
         priority if (rop == ipe_pkg::OP_MUL) begin
            red_done = mul_ff;
            res      = prod_ff;
         end else if (rop == ipe_pkg::OP_ADD) begin
            red_done = 1'b1;
            res      = ra + rb;
         end else if (rop == ipe_pkg::OP_SUB) begin
            red_done = 1'b1;
            res      = ra - rb;
         end else if (zero_div) begin
            red_done = 1'b1;
         end else begin
            red_done = div_done;
            res      = (rop == ipe_pkg::OP_DIV) ? qs : rs;
         end
      end
   end

   always_comb begin
      val_in      = val_ff;
      ops_in      = ops_ff;
      cnt_in      = cnt_ff;
      err_in      = err_ff;
      item_op_in  = item_op_ff;
      item_val_in = item_val_ff;
      red_in      = red_ff;
      if (cmd.start_reduce) red_in = 1'b1;
      if (red_done) begin
         red_in       = 1'b0;
         val_in[ridx] = res;
         val_in[cnt_ff] = '0;
         ops_in[ridx] = '0;
         cnt_in       = ridx;
         if (rop != ipe_pkg::OP_MUL && rop != ipe_pkg::OP_ADD &&
             rop != ipe_pkg::OP_SUB && zero_div) err_in = 1'b1;
      end
      if (cmd.push) begin
         ops_in[cnt_ff]       = item_op_ff;
         val_in[cnt_ff + 2'd1] = item_val_ff;
         cnt_in               = cnt_ff + 2'd1;
      end
      if (cmd.finish) begin
         for (int i = 0; i < ipe_pkg::ValDepth; i++) val_in[i] = '0;
         for (int i = 0; i < ipe_pkg::OpsDepth; i++) ops_in[i] = '0;
         cnt_in = '0;
         err_in = 1'b0;
      end
      if (cmd.load_item) begin
         item_op_in  = item.operator_code;
         item_val_in = item.operand;
         if (item.action == ipe_pkg::ACT_START) begin
            for (int i = 1; i < ipe_pkg::ValDepth; i++) val_in[i] = '0;
            for (int i = 0; i < ipe_pkg::OpsDepth; i++) ops_in[i] = '0;
            val_in[0] = item.operand;
            cnt_in    = '0;
            err_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ipe_pkg::ValDepth; i++) val_ff[i] <= '0;
         for (int i = 0; i < ipe_pkg::OpsDepth; i++) ops_ff[i] <= '0;
         cnt_ff <= '0;
         err_ff <= 1'b0;
         red_ff <= 1'b0;
         mul_ff <= 1'b0;
      end else begin
         val_ff <= val_in;
         ops_ff <= ops_in;
         cnt_ff <= cnt_in;
         err_ff <= err_in;
         red_ff <= red_in;
         mul_ff <= mul_in;
      end
      item_op_ff  <= item_op_in;
      item_val_ff <= item_val_in;
      prod_ff     <= ra * rb;
      if (cmd.start_reduce) begin
         sa_ff <= ra[Width-1];
         sb_ff <= rb[Width-1];
      end
   end

   assign sts.pending_any   = (cnt_ff != 2'd0);
   assign sts.reduce_needed = (cnt_ff != 2'd0) &&
                              (ipe_pkg::prec_of(rop) >= ipe_pkg::prec_of(item_op_ff));
   assign sts.stack_full    = (cnt_ff >= 2'(ipe_pkg::OpsDepth));
   assign sts.reduce_busy   = red_ff || div_busy;
   assign result.value          = val_ff[0];
   assign result.divide_by_zero = err_ff;

   assert property (@(posedge clock) disable iff (reset) div_start |=> div_busy)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) cmd.push |-> !red_ff)
      else $error("push during reduction");
   assert property (@(posedge clock) disable iff (reset) red_done |=> cnt_ff == $past(ridx))
      else $error("reduction did not pop");

endmodule

### sv/ipe_control.sv
module ipe_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ipe_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ipe_pkg::rsp_type  rsp_data,
   input  ipe_pkg::rsp_type  result,
   input  ipe_pkg::sts_type  sts,
   output ipe_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_REDUCE = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_WAIT   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic             end_ff, end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ipe_pkg::rsp_type rsp_ff, rsp_in;
   logic             accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               if (req_data.action == ipe_pkg::ACT_OPER &&
                   req_data.operator_code <= ipe_pkg::OP_REM) begin
                  end_in   = 1'b0;
                  state_in = ST_CHECK;
               end else if (req_data.action == ipe_pkg::ACT_END) begin
                  end_in   = 1'b1;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_CHECK: begin
            if (sts.reduce_needed) begin
               cmd.start_reduce = 1'b1;
               state_in         = ST_REDUCE;
            end else begin
               if (!sts.stack_full) cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (sts.pending_any) begin
               cmd.start_reduce = 1'b1;
               state_in         = ST_REDUCE;
            end else begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               cmd.finish   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REDUCE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!sts.reduce_busy) state_in = end_ff ? ST_FLUSH : ST_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) cmd.finish |=> rsp_valid)
      else $error("finish without response");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff != ST_IDLE |-> !req_ready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset) cmd.push |-> !cmd.start_reduce)
      else $error("push and reduce together");

endmodule

### sv/infix_precedence_evaluator_top.sv
// Items: a start item is loaded while idle; an operator item is checked, with one reduction
// per popped operator, then pushed if the stack has room; an end item reduces every pending
// operator, and its result is registered as the response. Reduction: add, subtract, multiply
// and a zero divisor skip the divider; divide and remainder share the one-bit-per-cycle divider.
// One item is in flight at a time; up to three reductions per item.
// Synchronous active-high reset empties both stacks and the error flag.
module infix_precedence_evaluator_top #(
   parameter int unsigned Width = ipe_pkg::DataWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ipe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ipe_pkg::rsp_type rsp_data
);

   ipe_pkg::cmd_type cmd;
   ipe_pkg::sts_type sts;
   ipe_pkg::rsp_type result;

   ipe_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .result(result), .sts(sts), .cmd(cmd)
   );

   ipe_datapath #(.Width(Width)) u_dp (
      .clock(clock), .reset(reset), .item(req_data),
      .cmd(cmd), .sts(sts), .result(result)
   );

endmodule
